FILE: design/pbfe_pkg.sv
package pbfe_pkg;

  localparam int unsigned TAG_W    = 32;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned TCNT_W   = 3;
  localparam int unsigned VCNT_W   = 4;
  localparam int unsigned GROUP_W  = 7;
  localparam int unsigned VGROUPS  = 10;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  typedef enum logic [1:0] {
    KIND_VARINT = 2'd0,
    KIND_BYTES  = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_NONE   = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] field_number;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       bad_field;
  } out_item_t;

  // One decoded item as handed to the byte emitter.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [VALUE_W-1:0] val;
    logic [TCNT_W-1:0]  tcnt;
    logic [VCNT_W-1:0]  vcnt;
    logic               raw;
    logic               bad;
  } emit_cmd_t;

  // Number of base-128 groups in the tag (at least one).
  function automatic logic [TCNT_W-1:0] tag_len(input logic [TAG_W-1:0] t);
    logic [TCNT_W-1:0] n;
    n = TCNT_W'(1);
    if (t[TAG_W-1:7] != '0)  n = n + TCNT_W'(1);
    if (t[TAG_W-1:14] != '0) n = n + TCNT_W'(1);
    if (t[TAG_W-1:21] != '0) n = n + TCNT_W'(1);
    if (t[TAG_W-1:28] != '0) n = n + TCNT_W'(1);
    return n;
  endfunction

  // Number of base-128 groups in a 64-bit value (at least one).
  function automatic logic [VCNT_W-1:0] val_len(input logic [VALUE_W-1:0] v);
    logic [VCNT_W-1:0] n;
    n = VCNT_W'(1);
    for (int k = 1; k < VGROUPS; k++) begin
      if ((v >> (GROUP_W * k)) != '0) n = n + VCNT_W'(1);
    end
    return n;
  endfunction

endpackage

FILE: design/pbfe_emit.sv
module pbfe_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  pbfe_pkg::emit_cmd_t  cmd,
  output logic                 free,
  output logic                 out_valid,
  output pbfe_pkg::out_item_t  out_item
);

  logic [pbfe_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [pbfe_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [pbfe_pkg::TCNT_W-1:0]  tcnt_r, tcnt_nxt;
  logic [pbfe_pkg::VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic                         raw_r, raw_nxt;
  logic                         bad_r, bad_nxt;
  logic                         last;

  assign out_valid = (vcnt_r != '0);
  assign last      = (tcnt_r == '0) && (vcnt_r == pbfe_pkg::VCNT_W'(1));
  assign free      = !out_valid || last;

  always_comb begin
    out_item.last_byte = last;
    out_item.bad_field = bad_r;
    if (tcnt_r != '0) begin
      out_item.out_byte = {(tcnt_r != pbfe_pkg::TCNT_W'(1)), tag_r[6:0]};
    end else if (raw_r) begin
      out_item.out_byte = val_r[7:0];
    end else begin
      out_item.out_byte = {(vcnt_r != pbfe_pkg::VCNT_W'(1)), val_r[6:0]};
    end
  end

  always_comb begin
    tag_nxt  = tag_r;
    val_nxt  = val_r;
    tcnt_nxt = tcnt_r;
    vcnt_nxt = vcnt_r;
    raw_nxt  = raw_r;
    bad_nxt  = bad_r;
    if (load) begin
      tag_nxt  = cmd.tag;
      val_nxt  = cmd.val;
      tcnt_nxt = cmd.tcnt;
      vcnt_nxt = cmd.vcnt;
      raw_nxt  = cmd.raw;
      bad_nxt  = cmd.bad;
    end else if (out_valid) begin
      // The tag goes out first, then the value, seven bits per byte (a raw byte carries eight).
      if (tcnt_r != '0) begin
        tcnt_nxt = tcnt_r - pbfe_pkg::TCNT_W'(1);
        tag_nxt  = tag_r >> pbfe_pkg::GROUP_W;
      end else begin
        vcnt_nxt = vcnt_r - pbfe_pkg::VCNT_W'(1);
        val_nxt  = val_r >> pbfe_pkg::GROUP_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcnt_r <= '0;
      vcnt_r <= '0;
    end else begin
      tcnt_r <= tcnt_nxt;
      vcnt_r <= vcnt_nxt;
    end
    tag_r <= tag_nxt;
    val_r <= val_nxt;
    raw_r <= raw_nxt;
    bad_r <= bad_nxt;
  end

`ifndef SYNTHESIS
  a_tag_has_value: assert property (@(posedge clk) disable iff (!rst_n)
    (tcnt_r != '0) |-> (vcnt_r != '0))
    else $error("tag bytes pending without a value byte");
  a_raw_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && raw_r) |-> out_item.last_byte)
    else $error("raw or error transaction longer than one byte");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("emitter loaded while a transaction is still in progress");
`endif

endmodule

FILE: design/protobuf_field_encoder.sv
// Protocol-buffer wire-format field encoder.
// Input: an item (in_item) is taken at a rising edge where start is high and
// busy is low. req_type selects a varint field, a bytes-field header or one
// raw payload byte; req_type 3 is taken and produces nothing.
// Output: one byte per cycle on out_item, marked by out_valid for exactly one
// cycle. last_byte flags the final byte of an item; bad_field flags the one
// result of a non-data item whose field number is zero or above 0x1fffffff.
// Path: an accepted item is registered in stage 1, then in stage 2, then in the
// byte emitter, whose registers drive its first byte; it waits while the next stage is full.
// Throughput: the byte emitter sends one byte per cycle. An item has 1 byte
// for a data byte or an error and 2 to 15 for a field (tag of 1-5 bytes plus
// value of 1-10 bytes). The two stages in front of the emitter hold further
// items, so busy rises only when both are full behind a long item.
// Reset (synchronous, rst_n low) empties all stages; no byte is pending.
// The receiver cannot stall: every strobed byte is taken.
module protobuf_field_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pbfe_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pbfe_pkg::out_item_t out_item
);

  pbfe_pkg::in_item_t  s1_r;
  logic                s1_v_r, s1_v_nxt;
  logic                s1_bad_r, s1_bad_nxt;
  pbfe_pkg::emit_cmd_t s2_r, s2_nxt;
  logic                s2_v_r, s2_v_nxt;

  logic accept;
  logic s3_free;
  logic s2_ready;
  logic s1_adv;
  logic s2_adv;
  logic [pbfe_pkg::TAG_W-1:0] tag;
  logic [2:0]                 wtype;

  assign s2_ready = !s2_v_r || s3_free;
  assign s2_adv   = s2_v_r && s3_free;
  assign s1_adv   = s1_v_r && s2_ready;
  assign busy     = s1_v_r && !s2_ready;
  assign accept   = start && !busy;

  // Stage 1: capture and check the field number.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = (in_item.req_type != pbfe_pkg::KIND_NONE);
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    s1_bad_nxt = (in_item.field_number == '0) || (in_item.field_number[31:29] != '0);
  end

  // Stage 2: build the tag and count the bytes of tag and value.
  assign wtype = (s1_r.req_type == pbfe_pkg::KIND_VARINT) ? pbfe_pkg::WT_VARINT
                                                           : pbfe_pkg::WT_LEN;
  assign tag   = {s1_r.field_number[28:0], wtype};

  always_comb begin
    s2_nxt      = s2_r;
    s2_v_nxt    = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
      if (s1_r.req_type == pbfe_pkg::KIND_DATA) begin
        s2_nxt.tag  = tag;
        s2_nxt.val  = {{(pbfe_pkg::VALUE_W-8){1'b0}}, s1_r.payload_byte};
        s2_nxt.tcnt = '0;
        s2_nxt.vcnt = pbfe_pkg::VCNT_W'(1);
        s2_nxt.raw  = 1'b1;
        s2_nxt.bad  = 1'b0;
      end else if (s1_bad_r) begin
        s2_nxt.tag  = tag;
        s2_nxt.val  = '0;
        s2_nxt.tcnt = '0;
        s2_nxt.vcnt = pbfe_pkg::VCNT_W'(1);
        s2_nxt.raw  = 1'b1;
        s2_nxt.bad  = 1'b1;
      end else begin
        s2_nxt.tag  = tag;
        s2_nxt.val  = s1_r.field_value;
        s2_nxt.tcnt = pbfe_pkg::tag_len(tag);
        s2_nxt.vcnt = pbfe_pkg::val_len(s1_r.field_value);
        s2_nxt.raw  = 1'b0;
        s2_nxt.bad  = 1'b0;
      end
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
    if (accept) begin
      s1_r     <= in_item;
      s1_bad_r <= s1_bad_nxt;
    end
    s2_r <= s2_nxt;
  end

  // Stage 3: serialise the item into bytes.
  pbfe_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s2_adv),
    .cmd       (s2_r),
    .free      (s3_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (s1_v_r && s2_v_r))
    else $error("busy raised while a stage is empty");
  a_none_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type == pbfe_pkg::KIND_NONE && !s1_v_r) |=> !s1_v_r)
    else $error("unused request type entered the pipeline");
  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (s1_v_r && $stable(s1_r)))
    else $error("stage 1 transaction changed while busy");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pbfe_pkg::*;

  localparam logic [31:0] FIELD_LIMIT = 32'h1fff_ffff;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 340;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  stim_t       stim_q[$];
  out_item_t   expected_bytes[$];
  stim_t       current;
  bit          have_current = 1'b0;
  int unsigned gap_left = 0;
  bit          burst_mode = 1'b0;
  int unsigned error_count = 0;
  int unsigned bytes_checked = 0;
  int unsigned cycle_count = 0;

  protobuf_field_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    // Keep the log readable if the block is badly broken.
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at byte %0d: %s", bytes_checked, msg);
    end
    error_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A value of random bit length, so that every varint length turns up.
  function automatic logic [63:0] rand_value();
    int unsigned w;
    logic [63:0] v;
    w = $urandom_range(0, 64);
    v = rand64();
    if (w < 64) begin
      v = v & ((64'h1 << w) - 64'h1);
    end
    return v;
  endfunction

  function automatic logic [31:0] valid_field();
    int unsigned w;
    logic [31:0] f;
    w = $urandom_range(1, 29);
    f = $urandom & ((32'h1 << w) - 32'h1);
    if (f == 32'h0) begin
      f = 32'h1;
    end
    return f;
  endfunction

  function automatic logic [31:0] invalid_field();
    logic [31:0] f;
    if ($urandom_range(0, 4) == 0) begin
      f = 32'h0;
    end else begin
      f = $urandom;
      if (f <= FIELD_LIMIT) begin
        f[31:29] = 3'($urandom_range(1, 7));
      end
    end
    return f;
  endfunction

  function automatic void queue_item(input logic [1:0] kind, input logic [31:0] field,
                                     input logic [63:0] value, input logic [7:0] pbyte,
                                     input bit drain);
    stim_t s;
    int unsigned r;
    s.item.req_type     = kind;
    s.item.field_number = field;
    s.item.field_value  = value;
    s.item.payload_byte = pbyte;
    s.drain = drain;
    if (burst_mode) begin
      s.gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        s.gap = 0;
      end else if (r < 85) begin
        s.gap = $urandom_range(1, 3);
      end else if (r < 96) begin
        s.gap = $urandom_range(4, 12);
      end else begin
        s.gap = $urandom_range(20, 60);
      end
    end
    stim_q.push_back(s);
  endfunction

  // Base-128 groups, low group first, continuation bit on all but the last.
  function automatic void push_varint(input logic [63:0] v);
    out_item_t b;
    b = '0;
    while (v >= 64'h80) begin
      b.out_byte = {1'b1, v[6:0]};
      expected_bytes.push_back(b);
      v = v >> 7;
    end
    b.out_byte = v[7:0];
    expected_bytes.push_back(b);
  endfunction

  function automatic void predict_encoding(input in_item_t it);
    out_item_t b;
    logic [63:0] tag;
    b = '0;
    case (it.req_type)
      KIND_DATA: begin
        b.out_byte  = it.payload_byte;
        b.last_byte = 1'b1;
        expected_bytes.push_back(b);
      end
      KIND_NONE: begin
      end
      default: begin
        if (it.field_number == 32'h0 || it.field_number > FIELD_LIMIT) begin
          b.last_byte = 1'b1;
          b.bad_field = 1'b1;
          expected_bytes.push_back(b);
        end else begin
          tag = (64'(it.field_number) << 3) |
                64'((it.req_type == KIND_BYTES) ? WT_LEN : WT_VARINT);
          push_varint(tag);
          push_varint(it.field_value);
          b = expected_bytes.pop_back();
          b.last_byte = 1'b1;
          expected_bytes.push_back(b);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : drive_items
    logic launch;
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
      have_current = 1'b0;
      gap_left = 0;
    end else begin
      launch = start;
      if (start && !busy) begin
        predict_encoding(in_item);
        launch = 1'b0;
      end
      if (!launch) begin
        if (!have_current && stim_q.size() != 0) begin
          current = stim_q.pop_front();
          have_current = 1'b1;
          gap_left = current.gap;
        end
        if (have_current) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (!current.drain || (expected_bytes.size() == 0 && !out_valid)) begin
            // A draining transaction waits until every byte owed has come out.
            launch = 1'b1;
            in_item <= current.item;
            have_current = 1'b0;
          end
        end
      end
      start <= launch;
    end
  end

  always @(posedge clk) begin : check_bytes
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", out_item.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        // On a bad field number the byte itself carries no meaning.
        if (!want.bad_field && out_item.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_item.out_byte, want.out_byte));
        end
        if (out_item.last_byte !== want.last_byte) begin
          report_mismatch($sformatf("last_byte %b, expected %b",
                                    out_item.last_byte, want.last_byte));
        end
        if (out_item.bad_field !== want.bad_field) begin
          report_mismatch($sformatf("bad_field %b, expected %b",
                                    out_item.bad_field, want.bad_field));
        end
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned items_made;
    int unsigned sel;
    int unsigned len;
    int unsigned n_data;
    bit drain;
    bit first;

    // Directed transactions: field and value extremes, tag length boundaries,
    // bad field numbers, the unused request type and raw data bytes.
    queue_item(KIND_VARINT, 32'd1, 64'd0, 8'h00, 1'b0);
    queue_item(KIND_VARINT, FIELD_LIMIT, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b0);
    queue_item(KIND_BYTES, 32'd15, 64'd3, 8'h5a, 1'b0);
    queue_item(KIND_DATA, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    queue_item(KIND_DATA, 32'h0, 64'h0, 8'hff, 1'b0);
    queue_item(KIND_DATA, 32'd7, 64'd9, 8'h80, 1'b0);
    queue_item(KIND_VARINT, 32'd16, 64'd127, 8'h00, 1'b0);
    queue_item(KIND_VARINT, 32'd2047, 64'd128, 8'h00, 1'b0);
    queue_item(KIND_BYTES, 32'd2048, 64'd16384, 8'h00, 1'b0);
    queue_item(KIND_VARINT, 32'h0003_ffff, 64'h8000_0000_0000_0000, 8'h00, 1'b0);
    queue_item(KIND_VARINT, 32'h0004_0000, 64'h7fff_ffff_ffff_ffff, 8'h00, 1'b0);
    queue_item(KIND_BYTES, FIELD_LIMIT, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    queue_item(KIND_VARINT, 32'h0, 64'd5, 8'h11, 1'b0);
    queue_item(KIND_BYTES, 32'h0, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b0);
    queue_item(KIND_VARINT, 32'h2000_0000, 64'd1, 8'h00, 1'b0);
    queue_item(KIND_BYTES, 32'hffff_ffff, 64'd0, 8'h00, 1'b0);
    queue_item(KIND_NONE, 32'd1, 64'd1, 8'haa, 1'b0);
    queue_item(KIND_NONE, 32'h0, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b0);
    queue_item(KIND_DATA, 32'd3, 64'd0, 8'ha5, 1'b0);
    queue_item(KIND_VARINT, 32'd1, 64'd300, 8'h00, 1'b0);

    // Random part: mostly varint fields and length-delimited headers followed
    // by their payload, with stray data bytes, bad fields and unused types.
    items_made = 0;
    first = 1'b1;
    while (items_made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        burst_mode = !burst_mode;
      end
      drain = first || ($urandom_range(0, 49) == 0);
      first = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        queue_item(KIND_VARINT, valid_field(), rand_value(), 8'($urandom), drain);
        items_made++;
      end else if (sel < 70) begin
        if ($urandom_range(0, 7) == 0) begin
          // Header whose payload is cut short or far too long to follow.
          queue_item(KIND_BYTES, valid_field(), rand_value(), 8'($urandom), drain);
          n_data = $urandom_range(0, 3);
        end else begin
          len = $urandom_range(0, 6);
          queue_item(KIND_BYTES, valid_field(), 64'(len), 8'($urandom), drain);
          n_data = len;
        end
        items_made++;
        repeat (n_data) begin
          queue_item(KIND_DATA, $urandom, rand64(), 8'($urandom), 1'b0);
          items_made++;
        end
      end else if (sel < 82) begin
        queue_item(KIND_DATA, $urandom, rand64(), 8'($urandom), drain);
        items_made++;
      end else if (sel < 94) begin
        queue_item(2'($urandom_range(0, 1)), invalid_field(), rand64(), 8'($urandom),
                   drain);
        items_made++;
      end else begin
        queue_item(KIND_NONE, $urandom, rand64(), 8'($urandom), drain);
      end
    end

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || have_current || start) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
